@@ sv/ldpsg_pkg.sv @@
// ---------------------------------------------------------------------------
// ldpsg_pkg
// Shared constants for the line doubler with padding and sync generation:
// configuration register indexes, register widths, reset values and
// counter widths.
// ---------------------------------------------------------------------------
package ldpsg_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SOURCE_ROWS = 3'd0,
        CFG_OUTPUT_ROWS = 3'd1,
        CFG_BLANK_TICKS = 3'd2,
        CFG_VSYNC_AT    = 3'd3,
        CFG_VSYNC_LEN   = 3'd4
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // register widths
    localparam int SRC_ROWS_W = 10;
    localparam int OUT_ROWS_W = 11;
    localparam int TICK8_W    = 8;

    // register reset values
    localparam logic [SRC_ROWS_W-1:0] SOURCE_ROWS_RST = 10'd339;
    localparam logic [OUT_ROWS_W-1:0] OUTPUT_ROWS_RST = 11'd768;
    localparam logic [TICK8_W-1:0]    BLANK_TICKS_RST = 8'd14;
    localparam logic [TICK8_W-1:0]    VSYNC_AT_RST    = 8'd5;
    localparam logic [TICK8_W-1:0]    VSYNC_LEN_RST   = 8'd10;

    // counter widths
    localparam int WORDS_W = 17;   // buffered and padded word counts
    localparam int LTICK_W = 9;    // tick within an output line
    localparam int RTICK_W = 20;   // ticks of the whole readout
    localparam int PHASE_W = 2;    // output line within a pair of row pairs

endpackage

@@ sv/line_doubler_pad_sync_gen_unit.sv @@
// ---------------------------------------------------------------------------
// line_doubler_pad_sync_gen_unit
// Buffers source rows in two ping-pong line stores, emits each row twice
// with blanking and hsync, pads zero rows to the output height and closes
// the frame with a vsync phase.
// ---------------------------------------------------------------------------
// One input item in, one result item out, at one item per clock while the
// output register is not held by m_tready low. Each item is taken in a cycle
// in which all frame state (buffer columns, line and readout tick counters,
// padding and vsync counters) advances; the line store reads issued in that
// cycle come back from the registered memory port on the next clock and the
// result then goes into the output register once that is free. A write
// and a read of the same store entry in the same item are bypassed so the
// read sees the new word. While the output register is held by m_tready low
// the unit still takes one more item into its middle stage. Configuration
// writes land at once; change them only while no items are in flight. The
// line stores are not cleared after reset: an entry must be written before
// it is read out, which normal operation guarantees.
// ---------------------------------------------------------------------------
module line_doubler_pad_sync_gen_unit #(
    parameter int ROW_WORDS = 64,
    parameter int WORD_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [ldpsg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ldpsg_pkg::CFG_DATA_W-1:0]    cfg_data,

    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((WORD_BITS+7)/8)*8-1:0]      s_tdata,   // pixel_word
    input  logic [1:0]                          s_tuser,   // word_valid, frame_start

    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((WORD_BITS+7)/8)*8-1:0]      m_tdata,   // out_word
    output logic                                m_tlast,   // out_eol
    output logic [3:0]                          m_tuser    // out_sof, out_valid,
                                                           // hsync_out, vsync_out
);

    localparam int DATA_W = ((WORD_BITS + 7) / 8) * 8;
    localparam int ADDR_W = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int COL_W  = ADDR_W + 1;   // holds ROW_WORDS itself
    localparam int WW     = ldpsg_pkg::WORDS_W;
    localparam int LW     = ldpsg_pkg::LTICK_W;
    localparam int RW     = ldpsg_pkg::RTICK_W;
    localparam int PW     = ldpsg_pkg::PHASE_W;
    localparam int TW     = ldpsg_pkg::TICK8_W;

    // configuration registers
    logic [ldpsg_pkg::SRC_ROWS_W-1:0] source_rows_reg;
    logic [ldpsg_pkg::OUT_ROWS_W-1:0] output_rows_reg;
    logic [TW-1:0]                    blank_ticks_reg;
    logic [TW-1:0]                    vsync_at_reg;
    logic [TW-1:0]                    vsync_len_reg;

    // frame state
    logic          write_sel_reg,    write_sel_next;
    logic [COL_W-1:0] write_col_a_reg, write_col_a_next;
    logic [COL_W-1:0] write_col_b_reg, write_col_b_next;
    logic [WW-1:0] buffered_reg,     buffered_next;
    logic          buffering_on_reg, buffering_on_next;
    logic          reading_on_reg,   reading_on_next;
    logic [PW-1:0] read_phase_reg,   read_phase_next;
    logic [LW-1:0] read_tick_reg,    read_tick_next;
    logic [RW-1:0] readout_reg,      readout_next;
    logic          padding_on_reg,   padding_on_next;
    logic [LW-1:0] pad_tick_reg,     pad_tick_next;
    logic [WW-1:0] padded_reg,       padded_next;
    logic          vsync_on_reg,     vsync_on_next;
    logic [TW-1:0] vsync_tick_reg,   vsync_tick_next;

    // line stores
    logic [WORD_BITS-1:0] store_a [ROW_WORDS];
    logic [WORD_BITS-1:0] store_b [ROW_WORDS];
    logic [WORD_BITS-1:0] rd_a_reg;
    logic [WORD_BITS-1:0] rd_b_reg;

    // per-item control from the update logic
    logic              we_a, we_b;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic              use_mem, sel_b, fwd;
    logic              sof, eol, vld, hs, vs;

    // middle stage
    logic                 v1_reg;
    logic                 use_mem1_reg, sel_b1_reg, fwd1_reg;
    logic [WORD_BITS-1:0] word1_reg;
    logic                 sof1_reg, eol1_reg, vld1_reg, hs1_reg, vs1_reg;

    // output register
    logic                 m_valid_reg;
    logic [WORD_BITS-1:0] out_word_reg;
    logic                 out_sof_reg, out_eol_reg, out_vld_reg, out_hs_reg, out_vs_reg;

    // derived frame geometry
    logic [LW-1:0]                    line_len;
    logic [ldpsg_pkg::OUT_ROWS_W-1:0] two_src;
    logic [ldpsg_pkg::OUT_ROWS_W-1:0] pad_rows;
    logic [WW-1:0]                    pad_target;
    logic [WW-1:0]                    buf_target;
    logic [RW-1:0]                    read_target;

    logic                 out_load;
    logic                 accept;
    logic [WORD_BITS-1:0] in_word;
    logic                 in_valid, in_start;

    assign out_load = !m_valid_reg || m_tready;
    assign s_tready = !v1_reg || out_load;
    assign accept   = s_tvalid && s_tready;

    assign in_word  = s_tdata[WORD_BITS-1:0];
    assign in_valid = s_tuser[0];
    assign in_start = s_tuser[1];

    // line length, padding rows and the end counts of each phase
    assign line_len    = LW'(ROW_WORDS) + LW'(blank_ticks_reg);
    assign two_src     = {source_rows_reg, 1'b0};
    assign pad_rows    = (output_rows_reg > two_src) ? (output_rows_reg - two_src)
                                                     : '0;
    assign pad_target  = WW'(WW'(pad_rows) * WW'(ROW_WORDS));
    assign buf_target  = WW'(WW'(source_rows_reg) * WW'(ROW_WORDS));
    assign read_target = RW'(RW'(line_len) * RW'(two_src));

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_rows_reg <= ldpsg_pkg::SOURCE_ROWS_RST;
            output_rows_reg <= ldpsg_pkg::OUTPUT_ROWS_RST;
            blank_ticks_reg <= ldpsg_pkg::BLANK_TICKS_RST;
            vsync_at_reg    <= ldpsg_pkg::VSYNC_AT_RST;
            vsync_len_reg   <= ldpsg_pkg::VSYNC_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ldpsg_pkg::CFG_SOURCE_ROWS: source_rows_reg <= cfg_data[9:0];
                ldpsg_pkg::CFG_OUTPUT_ROWS: output_rows_reg <= cfg_data;
                ldpsg_pkg::CFG_BLANK_TICKS: blank_ticks_reg <= cfg_data[7:0];
                ldpsg_pkg::CFG_VSYNC_AT:    vsync_at_reg    <= cfg_data[7:0];
                ldpsg_pkg::CFG_VSYNC_LEN:   vsync_len_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // per-item state update
    always_comb begin
        logic start;
        logic [LW-1:0] t;

        write_sel_next    = write_sel_reg;
        write_col_a_next  = write_col_a_reg;
        write_col_b_next  = write_col_b_reg;
        buffered_next     = buffered_reg;
        buffering_on_next = buffering_on_reg;
        reading_on_next   = reading_on_reg;
        read_phase_next   = read_phase_reg;
        read_tick_next    = read_tick_reg;
        readout_next      = readout_reg;
        padding_on_next   = padding_on_reg;
        pad_tick_next     = pad_tick_reg;
        padded_next       = padded_reg;
        vsync_on_next     = vsync_on_reg;
        vsync_tick_next   = vsync_tick_reg;
        we_a    = 1'b0;
        we_b    = 1'b0;
        wr_addr = '0;
        rd_addr = read_tick_reg[ADDR_W-1:0];
        use_mem = 1'b0;
        sel_b   = read_phase_reg[1];
        fwd     = 1'b0;
        eol     = 1'b0;
        vld     = 1'b0;
        hs      = 1'b0;

        // frame start counts only while not reading or padding
        start = in_start && !(padding_on_reg || reading_on_reg);
        if (start) begin
            buffering_on_next = 1'b1;
            buffered_next     = '0;
            write_col_a_next  = '0;
        end

        // ping-pong buffering
        if (buffering_on_next && in_valid) begin
            buffered_next = buffered_next + 1'b1;
            if (!write_sel_reg) begin
                we_a             = 1'b1;
                wr_addr          = write_col_a_next[ADDR_W-1:0];
                write_col_a_next = write_col_a_next + 1'b1;
            end else begin
                we_b             = 1'b1;
                wr_addr          = write_col_b_next[ADDR_W-1:0];
                write_col_b_next = write_col_b_next + 1'b1;
            end
        end

        // readout of doubled rows
        if (reading_on_reg) begin
            readout_next   = readout_reg + 1'b1;
            use_mem        = read_tick_reg < LW'(ROW_WORDS);
            read_tick_next = read_tick_reg + 1'b1;
        end
        // same-item write to the entry being read
        fwd = (sel_b ? we_b : we_a) && (wr_addr == rd_addr);

        // zero padding rows
        if (padding_on_reg) begin
            pad_tick_next = pad_tick_reg + 1'b1;
            use_mem       = 1'b0;
            if (pad_tick_next <= LW'(ROW_WORDS))
                padded_next = padded_reg + 1'b1;
        end

        if (vsync_on_reg)
            vsync_tick_next = vsync_tick_reg + 1'b1;

        // line flags from both line counters
        sof = (readout_next == RW'(1));
        for (int i = 0; i < 2; i++) begin
            t = (i == 0) ? read_tick_next : pad_tick_next;
            if (t == LW'(ROW_WORDS))
                eol = 1'b1;
            if (t >= LW'(1) && t <= LW'(ROW_WORDS))
                vld = 1'b1;
            if (t > LW'(ROW_WORDS + 1) && t < line_len)
                hs = 1'b1;
        end
        vs = (vsync_tick_next == vsync_at_reg);

        // row complete: swap stores
        if (write_col_a_next == COL_W'(ROW_WORDS)) begin
            write_sel_next   = 1'b1;
            write_col_a_next = '0;
        end else if (write_col_b_next == COL_W'(ROW_WORDS)) begin
            write_sel_next   = 1'b0;
            write_col_b_next = '0;
        end

        // line wrap
        if (read_tick_next == line_len) begin
            read_phase_next = read_phase_reg + 1'b1;
            read_tick_next  = '0;
        end
        if (pad_tick_next == line_len)
            pad_tick_next = '0;

        // first row in: readout starts; whole frame in: buffering stops
        if (buffered_next == WW'(ROW_WORDS))
            reading_on_next = 1'b1;
        if (buffered_next == buf_target) begin
            buffering_on_next = 1'b0;
            buffered_next     = '0;
        end

        // end of readout
        if (reading_on_next && readout_next == read_target) begin
            reading_on_next = 1'b0;
            readout_next    = '0;
            if (pad_target == '0) begin
                vsync_on_next   = 1'b1;
                pad_tick_next   = '0;
                padding_on_next = 1'b0;
                padded_next     = '0;
                write_sel_next  = 1'b0;
                read_phase_next = '0;
            end else begin
                padding_on_next = 1'b1;
            end
        end

        // end of padding
        if (padding_on_next && padded_next == pad_target) begin
            vsync_on_next   = 1'b1;
            pad_tick_next   = '0;
            padding_on_next = 1'b0;
            padded_next     = '0;
            write_sel_next  = 1'b0;
            read_phase_next = '0;
        end

        // end of vsync phase
        if (vsync_tick_next == vsync_len_reg) begin
            vsync_on_next   = 1'b0;
            vsync_tick_next = '0;
        end
    end

    // frame state registers, advance on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_sel_reg    <= 1'b0;
            write_col_a_reg  <= '0;
            write_col_b_reg  <= '0;
            buffered_reg     <= '0;
            buffering_on_reg <= 1'b0;
            reading_on_reg   <= 1'b0;
            read_phase_reg   <= '0;
            read_tick_reg    <= '0;
            readout_reg      <= '0;
            padding_on_reg   <= 1'b0;
            pad_tick_reg     <= '0;
            padded_reg       <= '0;
            vsync_on_reg     <= 1'b0;
            vsync_tick_reg   <= '0;
        end else if (accept) begin
            write_sel_reg    <= write_sel_next;
            write_col_a_reg  <= write_col_a_next;
            write_col_b_reg  <= write_col_b_next;
            buffered_reg     <= buffered_next;
            buffering_on_reg <= buffering_on_next;
            reading_on_reg   <= reading_on_next;
            read_phase_reg   <= read_phase_next;
            read_tick_reg    <= read_tick_next;
            readout_reg      <= readout_next;
            padding_on_reg   <= padding_on_next;
            pad_tick_reg     <= pad_tick_next;
            padded_reg       <= padded_next;
            vsync_on_reg     <= vsync_on_next;
            vsync_tick_reg   <= vsync_tick_next;
        end
    end

    // line store a: one write, one registered read
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (we_a)
                store_a[wr_addr] <= in_word;
            rd_a_reg <= store_a[rd_addr];
        end
    end

    // line store b
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (we_b)
                store_b[wr_addr] <= in_word;
            rd_b_reg <= store_b[rd_addr];
        end
    end

    // middle stage: waits for the store read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (accept) begin
            v1_reg <= 1'b1;
        end else if (out_load) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            use_mem1_reg <= use_mem;
            sel_b1_reg   <= sel_b;
            fwd1_reg     <= fwd;
            word1_reg    <= in_word;
            sof1_reg     <= sof;
            eol1_reg     <= eol;
            vld1_reg     <= vld;
            hs1_reg      <= hs;
            vs1_reg      <= vs;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && v1_reg) begin
            if (!use_mem1_reg)
                out_word_reg <= '0;
            else if (fwd1_reg)
                out_word_reg <= word1_reg;
            else
                out_word_reg <= sel_b1_reg ? rd_b_reg : rd_a_reg;
            out_sof_reg <= sof1_reg;
            out_eol_reg <= eol1_reg;
            out_vld_reg <= vld1_reg;
            out_hs_reg  <= hs1_reg;
            out_vs_reg  <= vs1_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_W'(out_word_reg);
    assign m_tlast  = out_eol_reg;
    assign m_tuser  = {out_vs_reg, out_hs_reg, out_vld_reg, out_sof_reg};

endmodule
